// ===== hdl/xalu_pkg.sv =====
package xalu_pkg;

    typedef enum logic [3:0] {
        CMD_MOV,
        CMD_SEXT32,
        CMD_ADD,
        CMD_SUB,
        CMD_CMP,
        CMD_CMOVNZ,
        CMD_AND,
        CMD_OR,
        CMD_XOR,
        CMD_NOT,
        CMD_IMUL_WIDE,
        CMD_IMUL,
        CMD_SHL,
        CMD_SHR,
        CMD_ROL,
        CMD_TEST_INC
    } cmd_t;

    typedef enum logic [1:0] {
        WIDTH_8,
        WIDTH_16,
        WIDTH_32,
        WIDTH_64
    } width_t;

    // Bit positions inside the kept flag word.
    localparam int FLAG_Z = 0;
    localparam int FLAG_S = 1;
    localparam int FLAG_C = 2;
    localparam int FLAG_O = 3;

    localparam logic [5:0] COUNT_MASK_WIDE   = 6'd63;
    localparam logic [5:0] COUNT_MASK_NARROW = 6'd31;

    typedef logic signed [65:0] pprod_t;

    // Everything the back half needs from the front half of one item.
    typedef struct packed {
        cmd_t        cmd;
        width_t      wcode;
        logic [63:0] res_lo;
        logic [63:0] alt_lo;
        logic        wb;
        logic [3:0]  fl_mask;
        logic [3:0]  fl_val;
        pprod_t      pp_ll;
        pprod_t      pp_lh;
        pprod_t      pp_hl;
        pprod_t      pp_hh;
    } mid_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        wb;
        logic [3:0]  flags;
    } res_t;

    function automatic logic [63:0] width_mask(width_t w);
        logic [63:0] m;
        unique case (w)
            WIDTH_8:  m = 64'h0000_0000_0000_00FF;
            WIDTH_16: m = 64'h0000_0000_0000_FFFF;
            WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
            WIDTH_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] width_bits(width_t w);
        logic [6:0] n;
        unique case (w)
            WIDTH_8:  n = 7'd8;
            WIDTH_16: n = 7'd16;
            WIDTH_32: n = 7'd32;
            WIDTH_64: n = 7'd64;
        endcase
        return n;
    endfunction

    function automatic logic top_bit(logic [63:0] v, width_t w);
        logic t;
        unique case (w)
            WIDTH_8:  t = v[7];
            WIDTH_16: t = v[15];
            WIDTH_32: t = v[31];
            WIDTH_64: t = v[63];
        endcase
        return t;
    endfunction

    function automatic logic [63:0] sign_ext(logic [63:0] v, width_t w);
        logic [63:0] r;
        unique case (w)
            WIDTH_8:  r = {{56{v[7]}}, v[7:0]};
            WIDTH_16: r = {{48{v[15]}}, v[15:0]};
            WIDTH_32: r = {{32{v[31]}}, v[31:0]};
            WIDTH_64: r = v;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/xalu_front.sv =====
module xalu_front
    import xalu_pkg::*;
(
    input  cmd_t        cmd,
    input  width_t      wcode,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic        is_increment,
    output mid_t        mid
);

    logic [63:0]        mask;
    logic [63:0]        a;
    logic [63:0]        b;
    logic [63:0]        sa;
    logic [63:0]        sb;
    logic [6:0]         nb;
    logic [5:0]         top_idx;
    logic [5:0]         cnt;
    logic [5:0]         rcnt;
    logic               cnt_big;
    logic [63:0]        shl_lo;
    logic [63:0]        shr_lo;
    logic [63:0]        rol_lo;
    logic               shl_c;
    logic               shr_c;
    logic signed [32:0] al_a;
    logic signed [32:0] ah_a;
    logic signed [32:0] al_b;
    logic signed [32:0] ah_b;
    logic               zs_en;

    assign mask    = width_mask(wcode);
    assign a       = operand_a & mask;
    assign b       = operand_b & mask;
    assign sa      = sign_ext(a, wcode);
    assign sb      = sign_ext(b, wcode);
    assign nb      = width_bits(wcode);
    assign top_idx = 6'(nb - 7'd1);

    assign cnt     = operand_b[5:0]
                     & ((wcode == WIDTH_64) ? COUNT_MASK_WIDE : COUNT_MASK_NARROW);
    assign rcnt    = operand_b[5:0] & top_idx;
    assign cnt_big = ({1'b0, cnt} >= nb);

    assign shl_lo = cnt_big ? 64'd0 : ((a << cnt) & mask);
    assign shr_lo = cnt_big ? 64'd0 : (a >> cnt);
    assign rol_lo = ((a << rcnt) | (a >> (6'(nb - {1'b0, rcnt}) & top_idx))) & mask;
    assign shl_c  = a[(6'd0 - cnt) & top_idx];
    assign shr_c  = a[(cnt - 6'd1) & top_idx];

    // The signed 64 by 64 product is built from four 33 by 33 signed pieces:
    // the low halves are zero-extended and the high halves carry the sign.
    assign al_a = signed'({1'b0, sa[31:0]});
    assign ah_a = signed'({sa[63], sa[63:32]});
    assign al_b = signed'({1'b0, sb[31:0]});
    assign ah_b = signed'({sb[63], sb[63:32]});

    always_comb
    begin
        mid         = '0;
        mid.cmd     = cmd;
        mid.wcode   = wcode;
        mid.alt_lo  = b;
        mid.wb      = 1'b1;
        mid.pp_ll   = al_a * al_b;
        mid.pp_lh   = al_a * ah_b;
        mid.pp_hl   = ah_a * al_b;
        mid.pp_hh   = ah_a * ah_b;
        zs_en       = 1'b0;

        unique case (cmd)
            CMD_MOV:       mid.res_lo = b;
            CMD_SEXT32:    mid.res_lo = {{32{operand_b[31]}}, operand_b[31:0]};
            CMD_ADD:
            begin
                mid.res_lo = (a + b) & mask;
                zs_en      = 1'b1;
            end
            CMD_SUB:
            begin
                mid.res_lo = (a - b) & mask;
                zs_en      = 1'b1;
            end
            CMD_CMP:
            begin
                mid.res_lo          = a;
                mid.wb              = 1'b0;
                mid.fl_mask[FLAG_Z] = 1'b1;
                mid.fl_val[FLAG_Z]  = (a == b);
            end
            CMD_CMOVNZ:    mid.res_lo = a;
            CMD_AND:
            begin
                mid.res_lo = a & b;
                zs_en      = 1'b1;
            end
            CMD_OR:
            begin
                mid.res_lo = a | b;
                zs_en      = 1'b1;
            end
            CMD_XOR:
            begin
                mid.res_lo = a ^ b;
                zs_en      = 1'b1;
            end
            CMD_NOT:       mid.res_lo = ~a & mask;
            CMD_IMUL_WIDE: mid.res_lo = '0;
            CMD_IMUL:      mid.res_lo = '0;
            CMD_SHL:
            begin
                mid.res_lo = shl_lo;
                if (cnt != 6'd0)
                begin
                    zs_en               = 1'b1;
                    mid.fl_mask[FLAG_C] = 1'b1;
                    mid.fl_mask[FLAG_O] = 1'b1;
                    mid.fl_val[FLAG_C]  = shl_c;
                    mid.fl_val[FLAG_O]  = shl_c ^ top_bit(shl_lo, wcode);
                end
            end
            CMD_SHR:
            begin
                mid.res_lo = shr_lo;
                if (cnt != 6'd0)
                begin
                    zs_en               = 1'b1;
                    mid.fl_mask[FLAG_C] = 1'b1;
                    mid.fl_mask[FLAG_O] = 1'b1;
                    mid.fl_val[FLAG_C]  = shr_c;
                    mid.fl_val[FLAG_O]  = top_bit(a, wcode);
                end
            end
            CMD_ROL:
            begin
                mid.res_lo          = rol_lo;
                mid.fl_mask[FLAG_C] = 1'b1;
                mid.fl_mask[FLAG_O] = 1'b1;
                mid.fl_val[FLAG_C]  = rol_lo[0];
                mid.fl_val[FLAG_O]  = top_bit(rol_lo, wcode) ^ rol_lo[0];
            end
            CMD_TEST_INC:
            begin
                if (is_increment)
                begin
                    mid.res_lo = (a + 64'd1) & mask;
                end
                else
                begin
                    mid.res_lo          = a & b;
                    mid.wb              = 1'b0;
                    zs_en               = 1'b1;
                    mid.fl_mask[FLAG_C] = 1'b1;
                    mid.fl_mask[FLAG_O] = 1'b1;
                end
            end
        endcase

        if (zs_en)
        begin
            mid.fl_mask[FLAG_Z] = 1'b1;
            mid.fl_mask[FLAG_S] = 1'b1;
            mid.fl_val[FLAG_Z]  = (mid.res_lo == 64'd0);
            mid.fl_val[FLAG_S]  = top_bit(mid.res_lo, wcode);
        end
    end

endmodule

// ===== hdl/xalu_back.sv =====
module xalu_back
    import xalu_pkg::*;
(
    input  mid_t        mid,
    input  logic [3:0]  flags_in,
    output res_t        res
);

    logic [63:0]  mask;
    logic [127:0] prod;
    logic [63:0]  prod_hi;

    assign mask = width_mask(mid.wcode);

    assign prod = {{62{mid.pp_ll[65]}}, mid.pp_ll}
                + ({{62{mid.pp_lh[65]}}, mid.pp_lh} << 32)
                + ({{62{mid.pp_hl[65]}}, mid.pp_hl} << 32)
                + ({{62{mid.pp_hh[65]}}, mid.pp_hh} << 64);

    // The upper half of the product starts right above the operand width.
    always_comb
    begin
        unique case (mid.wcode)
            WIDTH_8:  prod_hi = {56'd0, prod[15:8]};
            WIDTH_16: prod_hi = {48'd0, prod[31:16]};
            WIDTH_32: prod_hi = {32'd0, prod[63:32]};
            WIDTH_64: prod_hi = prod[127:64];
        endcase
    end

    always_comb
    begin
        res.hi    = '0;
        res.wb    = mid.wb;
        res.flags = (flags_in & ~mid.fl_mask) | (mid.fl_val & mid.fl_mask);

        unique case (mid.cmd)
            CMD_IMUL_WIDE:
            begin
                res.lo = prod[63:0] & mask;
                res.hi = prod_hi;
            end
            CMD_IMUL:   res.lo = prod[63:0] & mask;
            // A set ZF keeps the destination, a clear one moves the source.
            CMD_CMOVNZ: res.lo = flags_in[FLAG_Z] ? mid.res_lo : mid.alt_lo;
            default:    res.lo = mid.res_lo;
        endcase
    end

endmodule

// ===== hdl/x86_integer_alu_with_flags.sv =====
// An accepted item passes through the input, partial-product and result registers in turn.
// Throughput: one item per cycle through the input, partial-product and result registers;
// a stalled output holds only the full stages behind it, so empty stages still fill.
// The kept flags update as each item enters the result register, in item order.
// Reset clears all valid bits and the flags to zero.
module x86_integer_alu_with_flags
    import xalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  cmd,
    input  logic [1:0]  width_code,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic        is_increment,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    output logic        writes_dest,
    output logic        zero_flag,
    output logic        sign_flag,
    output logic        carry_flag,
    output logic        overflow_flag
);

    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    width_t      s1_wcode_reg;
    logic [63:0] s1_a_reg;
    logic [63:0] s1_b_reg;
    logic        s1_inc_reg;
    logic        s2_valid_reg;
    mid_t        mid_reg;
    mid_t        mid_next;
    logic        out_valid_reg;
    res_t        res_reg;
    res_t        res_next;
    logic [3:0]  flag_reg;
    logic        out_adv;
    logic        s2_adv;
    logic        s1_adv;

    assign out_adv  = !out_valid_reg || out_ready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    xalu_front u_front (
        .cmd          (s1_cmd_reg),
        .wcode        (s1_wcode_reg),
        .operand_a    (s1_a_reg),
        .operand_b    (s1_b_reg),
        .is_increment (s1_inc_reg),
        .mid          (mid_next)
    );

    xalu_back u_back (
        .mid      (mid_reg),
        .flags_in (flag_reg),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
                if (s2_valid_reg)
                begin
                    flag_reg <= res_next.flags;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_cmd_reg   <= cmd_t'(cmd);
            s1_wcode_reg <= width_t'(width_code);
            s1_a_reg     <= operand_a;
            s1_b_reg     <= operand_b;
            s1_inc_reg   <= is_increment;
        end
        if (s2_adv && s1_valid_reg)
        begin
            mid_reg <= mid_next;
        end
        if (out_adv && s2_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_low    = res_reg.lo;
    assign result_high   = res_reg.hi;
    assign writes_dest   = res_reg.wb;
    assign zero_flag     = res_reg.flags[FLAG_Z];
    assign sign_flag     = res_reg.flags[FLAG_S];
    assign carry_flag    = res_reg.flags[FLAG_C];
    assign overflow_flag = res_reg.flags[FLAG_O];

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import xalu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 100;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam int IDLE_PCT[4] = '{0, 73, 0, 7};
    localparam int STALL_PCT[4] = '{0, 0, 73, 7};

    typedef struct packed {
        logic [63:0] lo_val;
        logic [63:0] hi_val;
        logic        dest;
        logic [3:0]  flags;
    } alu_result_t;

    class alu_scoreboard;
        logic [3:0] kept_flags;
        alu_result_t pending_results[$];
        int mismatches;

        function new();
            kept_flags = '0;
            mismatches = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ns: %s", $time, msg);
        endfunction

        function logic msb(logic [63:0] v, int unsigned nb);
            return v[nb - 1];
        endfunction

        function void set_zs(logic [63:0] v, int unsigned nb);
            kept_flags[FLAG_Z] = (v == 64'd0);
            kept_flags[FLAG_S] = msb(v, nb);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Works out the result of one accepted item and advances the kept flags.
        function void note_item(cmd_t op, width_t wc, logic [63:0] a_raw, logic [63:0] b_raw,
                                logic inc);
            int unsigned nb;
            int unsigned sc;
            logic [63:0] m, a, b, lo, hi;
            logic [127:0] wide_a, wide_b, prod;
            logic dest, c;
            alu_result_t r;
            nb = 8 << int'(wc);
            m = (nb == 64) ? ALL_ONES : ((64'd1 << nb) - 64'd1);
            a = a_raw & m;
            b = b_raw & m;
            lo = '0;
            hi = '0;
            dest = 1'b1;
            case (op)
                CMD_MOV: lo = b;
                CMD_SEXT32:
                begin
                    lo = {{32{b_raw[31]}}, b_raw[31:0]};
                    m = ALL_ONES;
                end
                CMD_ADD:
                begin
                    lo = (a + b) & m;
                    set_zs(lo, nb);
                end
                CMD_SUB:
                begin
                    lo = (a - b) & m;
                    set_zs(lo, nb);
                end
                CMD_CMP:
                begin
                    lo = a;
                    dest = 1'b0;
                    kept_flags[FLAG_Z] = (a == b);
                end
                CMD_CMOVNZ: lo = kept_flags[FLAG_Z] ? a : b;
                CMD_AND:
                begin
                    lo = a & b;
                    set_zs(lo, nb);
                end
                CMD_OR:
                begin
                    lo = a | b;
                    set_zs(lo, nb);
                end
                CMD_XOR:
                begin
                    lo = a ^ b;
                    set_zs(lo, nb);
                end
                CMD_NOT: lo = ~a & m;
                CMD_IMUL_WIDE:
                begin
                    // Sign-extend both operands to 128 bits; the low 128 bits of the
                    // unsigned product equal the signed product.
                    wide_a = {64'd0, a};
                    wide_b = {64'd0, b};
                    if (msb(a, nb))
                        wide_a = wide_a | ~{64'd0, m};
                    if (msb(b, nb))
                        wide_b = wide_b | ~{64'd0, m};
                    prod = wide_a * wide_b;
                    lo = prod[63:0] & m;
                    prod = prod >> nb;
                    hi = prod[63:0] & m;
                end
                CMD_IMUL: lo = (a * b) & m;
                CMD_SHL:
                begin
                    sc = (nb == 64) ? (b_raw[5:0] & COUNT_MASK_WIDE)
                                    : (b_raw[5:0] & COUNT_MASK_NARROW);
                    lo = (sc >= nb) ? 64'd0 : ((a << sc) & m);
                    if (sc != 0)
                    begin
                        c = a[(0 - sc) & (nb - 1)];
                        kept_flags[FLAG_C] = c;
                        kept_flags[FLAG_O] = c ^ msb(lo, nb);
                        set_zs(lo, nb);
                    end
                end
                CMD_SHR:
                begin
                    sc = (nb == 64) ? (b_raw[5:0] & COUNT_MASK_WIDE)
                                    : (b_raw[5:0] & COUNT_MASK_NARROW);
                    lo = (sc >= nb) ? 64'd0 : (a >> sc);
                    if (sc != 0)
                    begin
                        kept_flags[FLAG_C] = a[(sc - 1) & (nb - 1)];
                        kept_flags[FLAG_O] = msb(a, nb);
                        set_zs(lo, nb);
                    end
                end
                CMD_ROL:
                begin
                    sc = b_raw[5:0] & (nb - 1);
                    lo = ((a << sc) | (a >> ((nb - sc) & (nb - 1)))) & m;
                    kept_flags[FLAG_C] = lo[0];
                    kept_flags[FLAG_O] = msb(lo, nb) ^ lo[0];
                end
                default:
                begin
                    if (inc)
                        lo = (a + 64'd1) & m;
                    else
                    begin
                        lo = a & b;
                        dest = 1'b0;
                        set_zs(lo, nb);
                        kept_flags[FLAG_C] = 1'b0;
                        kept_flags[FLAG_O] = 1'b0;
                    end
                end
            endcase
            r.lo_val = lo & m;
            r.hi_val = hi;
            r.dest = dest;
            r.flags = kept_flags;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [63:0] lo, logic [63:0] hi, logic dest,
                                   logic [3:0] flags);
            alu_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with no item pending: low %h high %h", lo, hi));
                return;
            end
            want = pending_results.pop_front();
            if (lo !== want.lo_val)
                report($sformatf("result_low expected %h got %h", want.lo_val, lo));
            if (hi !== want.hi_val)
                report($sformatf("result_high expected %h got %h", want.hi_val, hi));
            if (dest !== want.dest)
                report($sformatf("writes_dest expected %b got %b", want.dest, dest));
            if (flags !== want.flags)
                report($sformatf("flags OCSZ expected %b got %b", want.flags, flags));
        endfunction

        function void want_missing(alu_result_t r);
            report($sformatf("no result came for item with expected low %h", r.lo_val));
        endfunction

        function void close_out();
            while (pending_results.size() != 0)
            begin
                want_missing(pending_results.pop_front());
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  cmd = '0;
    logic [1:0]  width_code = '0;
    logic [63:0] operand_a = '0;
    logic [63:0] operand_b = '0;
    logic        is_increment = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        writes_dest;
    logic        zero_flag;
    logic        sign_flag;
    logic        carry_flag;
    logic        overflow_flag;

    alu_scoreboard alu_sb;
    int sender_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_request = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    x86_integer_alu_with_flags dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .width_code(width_code),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .is_increment(is_increment),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_low(result_low),
        .result_high(result_high),
        .writes_dest(writes_dest),
        .zero_flag(zero_flag),
        .sign_flag(sign_flag),
        .carry_flag(carry_flag),
        .overflow_flag(overflow_flag)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            alu_sb.note_item(cmd_t'(cmd), width_t'(width_code), operand_a, operand_b,
                             is_increment);
        if (out_valid && out_ready)
            alu_sb.check_result(result_low, result_high, writes_dest,
                                {overflow_flag, carry_flag, sign_flag, zero_flag});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(cmd_t op, width_t wc, logic [63:0] a, logic [63:0] b, logic inc);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        width_code <= wc;
        operand_a <= a;
        operand_b <= b;
        is_increment <= inc;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (alu_sb.pending() != 0);
        @(posedge clk);
    endtask

    function automatic logic [63:0] pick_operand(width_t wc);
        int unsigned nb;
        logic [63:0] v;
        nb = 8 << int'(wc);
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = ALL_ONES;
            2: v = 64'd1 << (nb - 1);
            3: v = (64'd1 << (nb - 1)) - 64'd1;
            4: v = $urandom_range(0, 3);
            5: v = 64'd1 << $urandom_range(0, 63);
            default: v = {$urandom, $urandom};
        endcase
        // Half the operands carry noise above the operand width.
        if (nb < 64 && $urandom_range(0, 1) == 0)
            v = v | ({$urandom, $urandom} << nb);
        return v;
    endfunction

    task automatic send_random();
        cmd_t op;
        width_t wc;
        int unsigned nb;
        logic [63:0] a, b;
        op = cmd_t'($urandom_range(0, 15));
        wc = width_t'($urandom_range(0, 3));
        nb = 8 << int'(wc);
        a = pick_operand(wc);
        b = pick_operand(wc);
        if ((op == CMD_SHL || op == CMD_SHR || op == CMD_ROL) && $urandom_range(0, 1) == 0)
            b[5:0] = 6'($urandom_range(0, nb + 1));
        else if ((op == CMD_SUB || op == CMD_CMP || op == CMD_XOR) &&
                 $urandom_range(0, 3) == 0)
            b = a;
        send_item(op, wc, a, b, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        alu_sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_MOV, WIDTH_64, 64'h0123_4567_89AB_CDEF, ALL_ONES, 1'b0);
        // Sign extension ignores the width code and the upper half of the source.
        send_item(CMD_SEXT32, WIDTH_8, 64'h0, 64'hFFFF_0000_8000_0001, 1'b0);
        send_item(CMD_SEXT32, WIDTH_16, ALL_ONES, 64'h1234_5678_7FFF_FFFF, 1'b0);
        send_item(CMD_ADD, WIDTH_8, 64'hFF, 64'h01, 1'b0);
        send_item(CMD_SUB, WIDTH_64, 64'h0, 64'h1, 1'b0);
        send_item(CMD_CMP, WIDTH_16, 64'hAAAA_1234, 64'h5555_1234, 1'b0);
        send_item(CMD_CMOVNZ, WIDTH_32, 64'h1111_1111, 64'h2222_2222, 1'b0);
        send_item(CMD_CMP, WIDTH_32, 64'h1, 64'h2, 1'b0);
        send_item(CMD_CMOVNZ, WIDTH_32, 64'h1111_1111, 64'h2222_2222, 1'b0);
        send_item(CMD_AND, WIDTH_64, ALL_ONES, MIN64, 1'b0);
        send_item(CMD_OR, WIDTH_8, 64'h0, 64'h0, 1'b0);
        send_item(CMD_XOR, WIDTH_32, 64'hCAFE_F00D, 64'hCAFE_F00D, 1'b0);
        send_item(CMD_NOT, WIDTH_16, 64'h00FF, 64'h0, 1'b0);
        send_item(CMD_IMUL_WIDE, WIDTH_64, MIN64, MIN64, 1'b0);
        send_item(CMD_IMUL_WIDE, WIDTH_64, ALL_ONES, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(CMD_IMUL_WIDE, WIDTH_8, 64'h80, 64'h7F, 1'b0);
        send_item(CMD_IMUL, WIDTH_32, ALL_ONES, ALL_ONES, 1'b0);
        // A rotate by zero still sets CF and OF; the zero-count shifts after it keep them.
        send_item(CMD_ROL, WIDTH_8, 64'h81, 64'h0, 1'b0);
        send_item(CMD_SHL, WIDTH_8, 64'hFF, 64'h20, 1'b0);
        send_item(CMD_SHR, WIDTH_64, ALL_ONES, 64'h40, 1'b0);
        send_item(CMD_SHL, WIDTH_8, 64'h81, 64'h9, 1'b0);
        send_item(CMD_SHL, WIDTH_64, 64'h1, 64'h3F, 1'b0);
        send_item(CMD_SHR, WIDTH_16, 64'h8001, 64'h1, 1'b0);
        send_item(CMD_ROL, WIDTH_64, MIN64, ALL_ONES, 1'b0);
        send_item(CMD_TEST_INC, WIDTH_16, 64'h8000, 64'hFFFF, 1'b0);
        send_item(CMD_TEST_INC, WIDTH_64, ALL_ONES, 64'h0, 1'b1);
        wait_drain();

        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = IDLE_PCT[p];
            rx_stall_pct <= STALL_PCT[p];
            repeat (470) send_random();
            if (p == 0)
            begin
                // Keep offering items while the receiver is held off so the pipe fills.
                hold_request <= hold_request + 1;
                repeat (60) send_random();
            end
            wait_drain();
        end

        repeat (10) @(posedge clk);
        alu_sb.close_out();
        if (alu_sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
